### hdl/mbe_pkg.sv
package mbe_pkg;

	// coordinate width after clamping, covers a mask side up to 1024
	localparam int CRD_W = 11;
	// box area width at the largest mask side (1024 * 1024)
	localparam int AREA_W = 21;
	localparam int REG_W = 9;
	localparam int REG_IDX_W = 2;
	localparam int LOGIT_W = 16;
	localparam int PIX_W = 8;
	localparam int MEAN_W = 16;
	localparam int SUM_W = 31;

	// shared divider widths
	localparam int DIV_N_W = 33;
	localparam int DIV_D_W = 21;

	localparam logic [REG_IDX_W-1:0] REG_BOX_LEFT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_RIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_TOP = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_BOTTOM = 2'd3;

	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// one classified pixel on its way from the front to the back
	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic in_box;
		logic last;
		logic nonempty;
		logic [AREA_W-1:0] area;
	} mbe_item_t;

	// round(65536 * exp(-2^(k-8))) for each bit of the Q8.8 magnitude
	function automatic logic [15:0] exp_coef(input logic [3:0] k);
		logic [15:0] c;
		case (k)
			4'd0: c = 16'd65280;
			4'd1: c = 16'd65026;
			4'd2: c = 16'd64520;
			4'd3: c = 16'd63520;
			4'd4: c = 16'd61565;
			4'd5: c = 16'd57835;
			4'd6: c = 16'd51039;
			4'd7: c = 16'd39750;
			4'd8: c = 16'd24109;
			4'd9: c = 16'd8869;
			4'd10: c = 16'd1200;
			4'd11: c = 16'd22;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

endpackage

### hdl/mbe_front.sv
module mbe_front import mbe_pkg::*; #(
	parameter int MASK_SIDE = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [REG_IDX_W-1:0]        wr_index,
	input  logic [REG_W-1:0]            wr_data,
	input  logic signed [LOGIT_W-1:0]   logit,
	input  logic [7:0]                  pixel_row,
	input  logic [7:0]                  pixel_col,
	input  logic                        frame_last,
	output mbe_item_t                   item
);

	localparam logic [CRD_W-1:0] SIDE = CRD_W'(MASK_SIDE);

	logic [REG_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [CRD_W-1:0] l, r, t, b, col, row, w, h;
	logic [2*CRD_W-1:0] prod;

	function automatic logic [CRD_W-1:0] clamp(input logic [REG_W-1:0] v);
		logic [CRD_W-1:0] x;
		x = CRD_W'(v);
		return (x > SIDE) ? SIDE : x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
			top_q <= '0;
			bottom_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BOX_LEFT: left_q <= wr_data;
				REG_BOX_RIGHT: right_q <= wr_data;
				REG_BOX_TOP: top_q <= wr_data;
				REG_BOX_BOTTOM: bottom_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		l = clamp(left_q);
		r = clamp(right_q);
		t = clamp(top_q);
		b = clamp(bottom_q);
		col = CRD_W'(pixel_col);
		row = CRD_W'(pixel_row);
		w = r - l;
		h = b - t;
		prod = w * h;
		item.logit = logit;
		item.in_box = (col >= l) && (col < r) && (row >= t) && (row < b);
		item.last = frame_last;
		item.nonempty = (r > l) && (b > t);
		item.area = prod[AREA_W-1:0];
	end

endmodule

### hdl/mbe_fifo.sv
module mbe_fifo import mbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mbe_item_t din,
	output logic      full,
	input  logic      pop,
	output mbe_item_t dout,
	output logic      valid
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	mbe_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### hdl/mbe_div.sv
module mbe_div import mbe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               done,
	output logic [DIV_N_W-1:0] quo,
	output logic [DIV_D_W-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIV_D_W-1:0] den_q, rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic done_q;
	logic [DIV_D_W:0] trial;
	logic fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign fits = (trial >= {1'b0, den_q});
	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

endmodule

### hdl/mbe_back.sv
module mbe_back import mbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  mbe_item_t         item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  out_pix,
	output logic [MEAN_W-1:0] out_mean,
	output logic              out_last
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0_0000_0000_0001,
		ST_EXP  = 13'b0_0000_0000_0010,
		ST_SDS  = 13'b0_0000_0000_0100,
		ST_SDIV = 13'b0_0000_0000_1000,
		ST_NRM  = 13'b0_0000_0001_0000,
		ST_LOG  = 13'b0_0000_0010_0000,
		ST_LSUB = 13'b0_0000_0100_0000,
		ST_MULP = 13'b0_0000_1000_0000,
		ST_MULL = 13'b0_0001_0000_0000,
		ST_ACC  = 13'b0_0010_0000_0000,
		ST_MDS  = 13'b0_0100_0000_0000,
		ST_MDIV = 13'b0_1000_0000_0000,
		ST_FIN  = 13'b1_0000_0000_0000
	} st_t;

	st_t st_q;
	mbe_item_t item_q;
	logic [3:0] cnt_q;
	logic neg_q;
	logic [11:0] mag_q;
	logic [16:0] e_q, p_q, m_q;
	logic [3:0] msb_q;
	logic [15:0] frac_q, v_q;
	logic [20:0] l_q, t_q;
	logic [SUM_W-1:0] sum_q;
	logic [PIX_W-1:0] pix_q;
	logic [MEAN_W-1:0] mean_q;

	logic [16:0] lx, mag;
	logic [32:0] e_mul;
	logic [33:0] m_sq;
	logic [17:0] m_sh;
	logic [36:0] pl, tv;
	logic [20:0] v_full;
	logic [SUM_W:0] sum_add;
	logic [23:0] pix_mul;
	logic [3:0] msb;
	logic [16:0] m_init;
	logic [17:0] sden;
	logic div_start, div_done;
	logic [DIV_N_W-1:0] div_num, div_quo;
	logic [DIV_D_W-1:0] div_den, div_rem;
	logic p_round;
	logic out_load;

	assign pop = (st_q == ST_IDLE) && item_valid;
	assign out_load = (st_q == ST_FIN) && (!out_valid || out_ready);

	always_comb begin
		lx = {item.logit[LOGIT_W-1], item.logit};
		mag = lx[16] ? (17'd0 - lx) : lx;
		e_mul = 33'(e_q) * 33'(exp_coef(cnt_q)) + 33'd32768;
		m_sq = 34'(m_q) * 34'(m_q);
		m_sh = m_sq[33:16];
		pl = 37'(p_q[15:0]) * 37'(l_q);
		tv = 37'(t_q) * 37'(LN2_Q16) + 37'd32768;
		v_full = tv[36:16];
		sum_add = {1'b0, sum_q} + (SUM_W+1)'(v_q);
		pix_mul = {v_q, 8'd0} - 24'(v_q);
		msb = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (p_q[i]) begin
				msb = 4'(i);
			end
		end
		m_init = 17'({1'b0, p_q[15:0]} << (5'd16 - {1'b0, msb}));
		sden = 18'd65536 + 18'(e_q);
		// round to nearest against the sigmoid denominator
		p_round = ({div_rem, 1'b0} >= 22'(sden));
	end

	// the divider serves the sigmoid and the frame mean
	always_comb begin
		div_start = (st_q == ST_SDS) || (st_q == ST_MDS);
		if (st_q == ST_SDS) begin
			div_num = neg_q ? {e_q, 16'd0} : {1'b1, 32'd0};
			div_den = DIV_D_W'(sden);
		end else begin
			div_num = DIV_N_W'(sum_q);
			div_den = item_q.area;
		end
	end

	mbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					neg_q <= lx[16];
					mag_q <= mag[11:0];
					e_q <= (mag >= 17'd4096) ? 17'd0 : 17'd65536;
					v_q <= '0;
				end
			end
			ST_EXP: begin
				if (mag_q[cnt_q]) begin
					e_q <= e_mul[32:16];
				end
			end
			ST_SDIV: begin
				if (div_done) begin
					p_q <= div_quo[16:0] + 17'(p_round);
				end
			end
			ST_NRM: begin
				msb_q <= msb;
				m_q <= m_init;
				frac_q <= '0;
				v_q <= '0;
			end
			ST_LOG: begin
				frac_q <= {frac_q[14:0], m_sh[17]};
				m_q <= m_sh[17] ? m_sh[17:1] : m_sh[16:0];
			end
			ST_LSUB: begin
				l_q <= {5'd16 - {1'b0, msb_q}, 16'd0} - 21'(frac_q);
			end
			ST_MULP: begin
				t_q <= pl[36:16];
			end
			ST_MULL: begin
				v_q <= (v_full > 21'd65535) ? 16'hFFFF : v_full[15:0];
			end
			ST_ACC: begin
				pix_q <= item_q.in_box ? pix_mul[23:16] : '0;
				mean_q <= '0;
			end
			ST_MDIV: begin
				if (div_done) begin
					mean_q <= (div_quo[DIV_N_W-1:MEAN_W] != '0) ? '1 : div_quo[MEAN_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// control and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			sum_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (item_valid) begin
						st_q <= item.in_box ? ST_EXP : ST_ACC;
					end
				end
				ST_EXP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd11) begin
						st_q <= ST_SDS;
					end
				end
				ST_SDS: st_q <= ST_SDIV;
				ST_SDIV: begin
					if (div_done) begin
						st_q <= ST_NRM;
					end
				end
				ST_NRM: begin
					cnt_q <= '0;
					st_q <= ((p_q == '0) || p_q[16]) ? ST_ACC : ST_LOG;
				end
				ST_LOG: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						st_q <= ST_LSUB;
					end
				end
				ST_LSUB: st_q <= ST_MULP;
				ST_MULP: st_q <= ST_MULL;
				ST_MULL: st_q <= ST_ACC;
				ST_ACC: begin
					if (item_q.in_box) begin
						sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
					end
					st_q <= (item_q.last && item_q.nonempty) ? ST_MDS : ST_FIN;
				end
				ST_MDS: st_q <= ST_MDIV;
				ST_MDIV: begin
					if (div_done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						if (item_q.last) begin
							sum_q <= '0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix <= pix_q;
			out_mean <= mean_q;
			out_last <= item_q.last;
		end
	end

endmodule

### hdl/mask_box_entropy.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: logit, pixel_row, pixel_col; tlast: frame_last
// m_*       out  m_tvalid/m_tready  tdata: entropy_pixel, mean_entropy; tlast: result_last
// wr_*      in   wr_en only         wr_index selects box_left/right/top/bottom, wr_data value
//
// a pixel outside the box skips the sigmoid and log2; an in-box pixel runs the 33-step
// shared divider (sigmoid) and the 16 squaring steps of log2, the latter skipped when p
// comes out as 0 or 1; the last pixel of a non-empty box adds the mean division
// arst_n clears box registers, running sum, queue and sequencer
// a two-entry queue parts the input from the back end, and a result register
// parts the back end from the output: either side may stall on its own
module mask_box_entropy import mbe_pkg::*; #(
	parameter int MASK_SIDE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // logit[15:0], pixel_row[23:16], pixel_col[31:24]
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // entropy_pixel[7:0], mean_entropy[23:8]
	output logic                 m_tlast,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0]     wr_data
);

	mbe_item_t front_item, queue_item;
	logic queue_full, queue_valid, queue_pop, push;
	logic [PIX_W-1:0] pix;
	logic [MEAN_W-1:0] mean;

	// an item enters the queue whenever there is room
	assign s_tready = !queue_full;
	assign push = s_tvalid && s_tready;

	// front: box registers, clamping, box test and area of the box
	mbe_front #(
		.MASK_SIDE (MASK_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.logit      (s_tdata[15:0]),
		.pixel_row  (s_tdata[23:16]),
		.pixel_col  (s_tdata[31:24]),
		.frame_last (s_tlast),
		.item       (front_item)
	);

	mbe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (queue_full),
		.pop    (queue_pop),
		.dout   (queue_item),
		.valid  (queue_valid)
	);

	// back: sigmoid, entropy term, running sum and frame mean
	mbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_valid),
		.item       (queue_item),
		.pop        (queue_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pix    (pix),
		.out_mean   (mean),
		.out_last   (m_tlast)
	);

	assign m_tdata = {mean, pix};

	// the mean is only ever reported on the last item of a frame
	a_mean_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'd0)
		else $error("mean reported on an item that is not last");

	// the entropy term never exceeds 65535, so the scaled byte stays below 255
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] != 8'hFF)
		else $error("pixel entropy byte out of range");

endmodule

### sim/tb_mask_box_entropy.sv
module tb_mask_box_entropy;
	timeunit 1ns;
	timeprecision 1ps;

	import mbe_pkg::*;

	localparam int SIDE = 256;
	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 8;
	localparam int ITEM_TARGET = 750;
	// receiver hold-off, long enough for the input queue to fill and stall
	localparam int HOLD_CYCLES = 800;
	// cycles with no item moving on either side before the run is given up
	localparam int STALL_LIMIT = 5000;
	// settle time after the last result, above the slowest pixel plus mean division
	localparam int SETTLE_CYCLES = 150;
	localparam longint unsigned LN2_FRAC = 45426;
	localparam longint unsigned SUM_LIMIT = 64'h7FFF_FFFF;

	// one pixel as offered on the input stream
	typedef struct packed {
		logic [15:0] logit;
		logic [7:0]  row;
		logic [7:0]  col;
		logic        last;
	} pixel_t;

	// one result as expected on the output stream
	typedef struct packed {
		logic [7:0]  pix;
		logic [15:0] mean;
		logic        last;
	} entropy_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;     // logit[15:0], pixel_row[23:16], pixel_col[31:24]
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;          // entropy_pixel[7:0], mean_entropy[23:8]
	logic                 m_tlast;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [REG_W-1:0]     wr_data = '0;

	// pixels waiting for the driver, results waiting for the output
	pixel_t       pix_queue[$];
	entropy_res_t expected_res[$];

	// predictor copy of the box registers and the running sum
	logic [REG_W-1:0] cfg_left = '0;
	logic [REG_W-1:0] cfg_right = '0;
	logic [REG_W-1:0] cfg_top = '0;
	logic [REG_W-1:0] cfg_bottom = '0;
	longint unsigned  run_sum = 0;

	int err_count = 0;
	int pix_sent = 0;
	int quiet_cycles = 0;
	logic in_taken = 1'b0;

	// sender burst state
	pixel_t next_pix;
	int burst_left = 0;
	int gap_left = 0;

	// receiver stall state; hold_seq is bumped by the stimulus to ask for a hold-off
	int rx_cycle = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	entropy_res_t want_res;
	entropy_res_t new_res;

	mask_box_entropy #(
		.MASK_SIDE(SIDE)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ---------------------------------------------------------------
	// entropy predictor
	// ---------------------------------------------------------------

	// exp(-2^(k-8)) in Q0.16, one factor per magnitude bit
	function automatic longint unsigned decay_factor(input int k);
		case (k)
			0: return 65280;
			1: return 65026;
			2: return 64520;
			3: return 63520;
			4: return 61565;
			5: return 57835;
			6: return 51039;
			7: return 39750;
			8: return 24109;
			9: return 8869;
			10: return 1200;
			11: return 22;
			default: return 0;
		endcase
	endfunction

	// exp(-mag/256) in Q1.16, built bit by bit with rounding
	function automatic longint unsigned exp_decay(input int unsigned mag);
		longint unsigned e;
		int k;
		e = 65536;
		if (mag >= 4096)
			return 0;
		for (k = 0; k < 12; k++) begin
			if ((mag >> k) & 1)
				e = (e * decay_factor(k) + 32768) >> 16;
		end
		return e;
	endfunction

	// sigmoid of a Q8.8 logit, Q1.16 result rounded to nearest
	function automatic longint unsigned sigmoid_prob(input logic [15:0] raw);
		int unsigned mag;
		longint unsigned e, d, one32;
		one32 = 64'd1 << 32;
		mag = raw[15] ? (32'h10000 - raw) : raw;
		e = exp_decay(mag);
		d = 65536 + e;
		if (!raw[15])
			return one32 / d + (((one32 % d) * 2 >= d) ? 1 : 0);
		return (65536 * e + d / 2) / d;
	endfunction

	// -log2(p) in Q5.16: integer part from the top bit, fraction by squaring
	function automatic longint unsigned info_bits(input longint unsigned p);
		int top, i;
		longint unsigned m, frac;
		top = 0;
		frac = 0;
		while (top < 16 && (p >> (top + 1)) != 0)
			top++;
		m = p << (16 - top);
		for (i = 0; i < 16; i++) begin
			m = (m * m) >> 16;
			frac = frac << 1;
			if (m >= 131072) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(16 - top) << 16) - frac;
	endfunction

	// -p*ln(p) in Q0.16; zero for a certain or impossible pixel
	function automatic longint unsigned pixel_entropy(input logic [15:0] raw);
		longint unsigned p, t, v;
		p = sigmoid_prob(raw);
		if (p == 0 || p >= 65536)
			return 0;
		t = (p * info_bits(p)) >> 16;
		v = (t * LN2_FRAC + 32768) >> 16;
		return (v > 65535) ? 65535 : v;
	endfunction

	function automatic int unsigned clamp_side(input logic [REG_W-1:0] v);
		return (v > SIDE) ? SIDE : v;
	endfunction

	// expected result for one accepted pixel, updates the running sum
	function automatic entropy_res_t predict_entropy(input logic [15:0] raw,
			input logic [7:0] row, input logic [7:0] col, input logic last);
		entropy_res_t res;
		int unsigned l, r, t, b, area;
		longint unsigned v, s;
		l = clamp_side(cfg_left);
		r = clamp_side(cfg_right);
		t = clamp_side(cfg_top);
		b = clamp_side(cfg_bottom);
		res = '0;
		if (col >= l && col < r && row >= t && row < b) begin
			v = pixel_entropy(raw);
			s = run_sum + v;
			res.pix = 8'((v * 255) >> 16);
			run_sum = (s > SUM_LIMIT) ? SUM_LIMIT : s;
		end
		if (last) begin
			// an empty box reports a zero mean
			if (r > l && b > t) begin
				area = (r - l) * (b - t);
				s = run_sum / area;
				res.mean = (s > 65535) ? 16'hFFFF : 16'(s);
			end
			run_sum = 0;
		end
		res.last = last;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		err_count++;
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got_v, want_v);
	endtask

	// ---------------------------------------------------------------
	// driver: bursts of items with random gaps
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pix_queue.size() > 0) begin
				next_pix = pix_queue.pop_front();
				s_tdata <= {next_pix.col, next_pix.row, next_pix.logit};
				s_tlast <= next_pix.last;
				s_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					// a third of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: rotating stall pattern, plus a long hold-off on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((rx_cycle >> 8) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// monitor: register copy, prediction on input, check on output
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (wr_en) begin
				case (wr_index)
					REG_BOX_LEFT: cfg_left = wr_data;
					REG_BOX_RIGHT: cfg_right = wr_data;
					REG_BOX_TOP: cfg_top = wr_data;
					REG_BOX_BOTTOM: cfg_bottom = wr_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				new_res = predict_entropy(s_tdata[15:0], s_tdata[23:16], s_tdata[31:24], s_tlast);
				expected_res = {expected_res, new_res};
			end
			if (m_tvalid && m_tready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected item", m_tdata[7:0], -1);
				end else begin
					want_res = expected_res.pop_front();
					if (m_tdata[7:0] !== want_res.pix)
						report_mismatch("entropy_pixel", m_tdata[7:0], want_res.pix);
					if (m_tdata[23:8] !== want_res.mean)
						report_mismatch("mean_entropy", m_tdata[23:8], want_res.mean);
					if (m_tlast !== want_res.last)
						report_mismatch("result_last", m_tlast, want_res.last);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: nothing moving for too long ends the run
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic void add_pixel(input logic [15:0] logit, input logic [7:0] row,
			input logic [7:0] col, input logic last);
		pixel_t it;
		it.logit = logit;
		it.row = row;
		it.col = col;
		it.last = last;
		pix_queue = {pix_queue, it};
		pix_sent++;
	endfunction

	// block idle: nothing left to send and every result back
	task automatic wait_idle();
		while (!(pix_queue.size() == 0 && !s_tvalid && expected_res.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= REG_W'(val);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_box(input int unsigned l, input int unsigned r,
			input int unsigned t, input int unsigned b);
		set_reg(REG_BOX_LEFT, l);
		set_reg(REG_BOX_RIGHT, r);
		set_reg(REG_BOX_TOP, t);
		set_reg(REG_BOX_BOTTOM, b);
	endtask

	// mostly the sigmoid's busy region, some full-range and edge values
	function automatic logic [15:0] rand_logit();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					4: return 16'h1000;
					5: return 16'hF000;
					6: return 16'h0FFF;
					default: return 16'hF001;
				endcase
			end
			1, 2: return 16'($urandom);
			default: return 16'($urandom_range(0, 4095) - 2048);
		endcase
	endfunction

	// one frame in raster order over a window around the box, with some
	// stray pixels, the odd unterminated frame and the odd mid-frame write
	task automatic add_frame(input int l, input int r, input int t, input int b);
		int n, w, split, k, row, col;
		bit open_end;
		n = $urandom_range(2, 24);
		w = (r > l && r - l <= 14) ? r - l + 2 : $urandom_range(2, 16);
		split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
		open_end = ($urandom_range(0, 9) == 0);
		for (k = 0; k < n; k++) begin
			if (k == split) begin
				wait_idle();
				set_reg(REG_IDX_W'($urandom_range(0, 3)), $urandom_range(0, 511));
			end
			if ($urandom_range(0, 6) == 0) begin
				row = $urandom_range(0, 255);
				col = $urandom_range(0, 255);
			end else begin
				row = t - 1 + k / w;
				col = l - 1 + k % w;
			end
			add_pixel(rand_logit(), 8'(row), 8'(col), !open_end && k == n - 1);
		end
	endtask

	initial begin
		int l, r, t, b, phase, nfr, f, i;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// whole mask, bounds beyond the side clamp down to it
		set_box(0, 511, 0, 300);
		add_pixel(16'h0000, 8'd0, 8'd0, 1'b0);
		add_pixel(16'h7FFF, 8'd255, 8'd255, 1'b0);   // certain pixel
		add_pixel(16'h8000, 8'd0, 8'd255, 1'b0);     // zero probability
		add_pixel(16'hFFFF, 8'd255, 8'd0, 1'b0);
		add_pixel(16'h0001, 8'd17, 8'd200, 1'b0);
		add_pixel(16'h0FFF, 8'd170, 8'd85, 1'b0);    // largest magnitude below cutoff
		add_pixel(16'h1000, 8'd85, 8'd170, 1'b0);    // magnitude cutoff
		add_pixel(16'hF000, 8'd1, 8'd2, 1'b0);
		add_pixel(16'hF001, 8'd3, 8'd4, 1'b0);
		add_pixel(16'hFF75, 8'd128, 8'd127, 1'b0);   // near peak entropy
		add_pixel(16'h0100, 8'd64, 8'd64, 1'b0);
		add_pixel(16'hFF00, 8'd200, 8'd100, 1'b0);
		add_pixel(16'h0080, 8'd128, 8'd64, 1'b1);
		wait_idle();

		// one-pixel box hit repeatedly, the mean saturates
		set_box(5, 6, 7, 8);
		for (i = 0; i < 4; i++)
			add_pixel(16'hFF75, 8'd7, 8'd5, 1'b0);
		add_pixel(16'hFF75, 8'd7, 8'd6, 1'b0);
		add_pixel(16'h0000, 8'd8, 8'd5, 1'b0);
		add_pixel(16'hFF75, 8'd7, 8'd5, 1'b1);
		wait_idle();

		// empty boxes give a zero mean
		set_box(200, 100, 20, 10);
		add_pixel(16'h0000, 8'd15, 8'd150, 1'b0);
		add_pixel(16'hFFC0, 8'd15, 8'd150, 1'b1);
		wait_idle();
		set_box(100, 100, 0, 256);
		add_pixel(16'h0040, 8'd5, 8'd100, 1'b1);
		wait_idle();

		// random phases: a new box, then a few frames
		phase = 0;
		while (pix_sent < ITEM_TARGET) begin
			wait_idle();
			case ($urandom_range(0, 7))
				0: begin
					l = 0;
					r = $urandom_range(256, 511);
					t = 0;
					b = $urandom_range(256, 511);
				end
				1: begin
					l = $urandom_range(0, 300);
					r = $urandom_range(0, l);
					t = $urandom_range(0, 255);
					b = $urandom_range(0, 511);
				end
				2: begin
					l = $urandom_range(240, 511);
					r = $urandom_range(250, 511);
					t = $urandom_range(240, 511);
					b = $urandom_range(250, 511);
				end
				default: begin
					l = $urandom_range(0, 250);
					r = l + $urandom_range(1, 10);
					t = $urandom_range(0, 250);
					b = t + $urandom_range(1, 10);
				end
			endcase
			set_box(l, r, t, b);
			nfr = $urandom_range(1, 3);
			// one phase runs under a long receiver hold-off so the input backs up
			if (phase == 2) begin
				hold_seq++;
				nfr = 3;
			end
			for (f = 0; f < nfr; f++)
				add_frame(clamp_side(REG_W'(l)), clamp_side(REG_W'(r)),
					clamp_side(REG_W'(t)), clamp_side(REG_W'(b)));
			phase++;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/mbe_pkg.sv
hdl/mbe_front.sv
hdl/mbe_fifo.sv
hdl/mbe_div.sv
hdl/mbe_back.sv
hdl/mask_box_entropy.sv
sim/tb_mask_box_entropy.sv
